[hdl/gmg_pkg.sv]
// Shared types, constants and calendar tables for the month grid layout block.
// Used by the controller, the datapath and the top level.
package gmg_pkg;

	localparam int unsigned YearW  = 12;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned RowW   = 3;
	localparam int unsigned ColW   = 3;

	localparam logic [YearW-1:0]  FIRST_YEAR = 12'd1583;
	// floor(x/4) - floor(x/100) + floor(x/400) at x = 1582
	localparam logic [YearW-1:0]  LEAP_BASE  = 12'd383;
	localparam logic [MonthW-1:0] LAST_MONTH = 4'd11;
	// floor(x / 100) = (x * RECIP_100) >> 17 for x < 4096
	localparam logic [10:0]       RECIP_100  = 11'd1311;
	// floor(x / 7) = (x * RECIP_7) >> 16 for x < 4096
	localparam logic [13:0]       RECIP_7    = 14'd9363;
	localparam logic [ColW-1:0]   COL_LAST   = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC1,
		ST_CALC2,
		ST_CALC3,
		ST_INIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic month_bad;
		logic last;
	} status_t;

	function automatic logic [DayW-1:0] month_len(input logic lp, input logic [MonthW-1:0] m);
		logic [DayW-1:0] len;
		case (m)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
			4'd1:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd31;
		endcase
		return len;
	endfunction

	// days before month m, modulo 7: table for a non-leap year, plus one from March on when lp is set
	function automatic logic [2:0] month_offset(input logic lp, input logic [MonthW-1:0] m);
		logic [2:0] off;
		case (m)
			4'd0:    off = 3'd0;
			4'd1:    off = 3'd3;
			4'd2:    off = 3'd3;
			4'd3:    off = 3'd6;
			4'd4:    off = 3'd1;
			4'd5:    off = 3'd4;
			4'd6:    off = 3'd6;
			4'd7:    off = 3'd2;
			4'd8:    off = 3'd5;
			4'd9:    off = 3'd0;
			4'd10:   off = 3'd3;
			4'd11:   off = 3'd5;
			default: off = 3'd0;
		endcase
		if (lp && m >= 4'd2 && off == 3'd6) begin
			off = 3'd0;
		end else if (lp && m >= 4'd2) begin
			off = off + 3'd1;
		end
		return off;
	endfunction

endpackage

[hdl/gmg_req_if.sv]
// Request channel: year and month under a valid/ready handshake.
// Standalone; no package dependency.
interface gmg_req_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;

	modport source (output valid, output year, output month, input ready);
	modport sink   (input valid, input year, input month, output ready);
endinterface

[hdl/gmg_day_if.sv]
// Result channel: one grid cell per transaction under a valid/ready handshake.
// Standalone; no package dependency.
interface gmg_day_if;
	logic       valid;
	logic       ready;
	logic [4:0] day_number;
	logic [2:0] week_row;
	logic [2:0] weekday_column;
	logic       last;

	modport source (output valid, output day_number, output week_row,
		output weekday_column, output last, input ready);
	modport sink   (input valid, input day_number, input week_row,
		input weekday_column, input last, output ready);
endinterface

[hdl/gmg_ctrl.sv]
// Controller state machine: sequences the weekday computation and day emission.
// Depends on gmg_pkg.
module gmg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            day_valid,
	input  logic            day_ready,
	input  gmg_pkg::status_t status,
	output gmg_pkg::cmd_t    cmd
);
	import gmg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && !status.month_bad) begin
					state_d = ST_CALC1;
				end
			end
			ST_CALC1: state_d = ST_CALC2;
			ST_CALC2: state_d = ST_CALC3;
			ST_CALC3: state_d = ST_INIT;
			ST_INIT:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (day_ready && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		day_valid   = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_INIT: cmd.init = 1'b1;
			ST_EMIT: begin
				day_valid   = 1'b1;
				cmd.advance = day_ready;
			end
			default: ;
		endcase
	end

endmodule

[hdl/gmg_dp.sv]
// Datapath: first-weekday arithmetic over three register stages, then the day walker.
// Depends on gmg_pkg.
module gmg_dp (
	input  logic                      clk,
	input  logic [gmg_pkg::YearW-1:0]  year,
	input  logic [gmg_pkg::MonthW-1:0] month,
	input  gmg_pkg::cmd_t              cmd,
	output gmg_pkg::status_t           status,
	output logic [gmg_pkg::DayW-1:0]   day_number,
	output logic [gmg_pkg::RowW-1:0]   week_row,
	output logic [gmg_pkg::ColW-1:0]   weekday_column
);
	import gmg_pkg::*;

	logic [YearW-1:0]  year_q;
	logic [MonthW-1:0] month_q;

	logic [YearW-1:0]  ym1;
	logic [22:0]       prod_a;
	logic [22:0]       prod_y;
	logic [YearW-1:0]  n_s1;
	logic              after_s1;
	logic [5:0]        qa_s1;
	logic [5:0]        qy_s1;

	logic [YearW-1:0]  leaps;
	logic [YearW-1:0]  rem100;
	logic [YearW-1:0]  sum_s2;
	logic              leap_s2;

	logic [25:0]       prod_7;
	logic [9:0]        q7_s3;
	logic [YearW-1:0]  sum_s3;
	logic              leap_s3;

	logic [12:0]       rem7_w;
	logic [4:0]        col_sum;
	logic [ColW-1:0]   col_first;

	logic [DayW-1:0]   day_q;
	logic [DayW-1:0]   len_q;
	logic [RowW-1:0]   row_q;
	logic [ColW-1:0]   col_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= year;
			month_q <= month;
		end
	end

	// stage 1: years elapsed and quotients by 100
	assign ym1    = year_q - 12'd1;
	assign prod_a = {11'd0, ym1} * {12'd0, RECIP_100};
	assign prod_y = {11'd0, year_q} * {12'd0, RECIP_100};

	always_ff @(posedge clk) begin
		after_s1 <= (year_q > FIRST_YEAR);
		n_s1     <= (year_q > FIRST_YEAR) ? (year_q - FIRST_YEAR) : '0;
		qa_s1    <= prod_a[22:17];
		qy_s1    <= prod_y[22:17];
	end

	// stage 2: leap count since the epoch and leap flag of the year
	assign leaps  = {2'd0, ym1[11:2]} - {6'd0, qa_s1} + {8'd0, qa_s1[5:2]} - LEAP_BASE;
	assign rem100 = year_q - 12'({6'd0, qy_s1} * 12'd100);

	always_ff @(posedge clk) begin
		sum_s2  <= n_s1 + (after_s1 ? leaps : '0);
		leap_s2 <= (year_q[1:0] == 2'd0) && ((rem100 != '0) || (qy_s1[1:0] == 2'd0));
	end

	// stage 3: quotient by 7
	assign prod_7 = {14'd0, sum_s2} * {12'd0, RECIP_7};

	always_ff @(posedge clk) begin
		q7_s3   <= prod_7[25:16];
		sum_s3  <= sum_s2;
		leap_s3 <= leap_s2;
	end

	assign rem7_w  = {1'b0, sum_s3} - {q7_s3, 3'd0} + {3'd0, q7_s3};
	assign col_sum = {2'd0, rem7_w[2:0]} + {2'd0, month_offset(leap_s3, month_q)} + 5'd6;

	always_comb begin
		if (col_sum >= 5'd14) begin
			col_first = 3'(col_sum - 5'd14);
		end else if (col_sum >= 5'd7) begin
			col_first = 3'(col_sum - 5'd7);
		end else begin
			col_first = col_sum[2:0];
		end
	end

	// day walker
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			day_q <= 5'd1;
			row_q <= '0;
			col_q <= col_first;
			len_q <= month_len(leap_s3, month_q);
		end else if (cmd.advance) begin
			day_q <= day_q + 5'd1;
			if (col_q == COL_LAST) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	assign status.month_bad = (month > LAST_MONTH);
	assign status.last      = (day_q == len_q);
	assign day_number       = day_q;
	assign week_row         = row_q;
	assign weekday_column   = col_q;

endmodule

[hdl/gregorian_month_grid_layout_top.sv]
// Top level of the month grid layout block: controller plus datapath.
// Depends on gmg_pkg, gmg_req_if, gmg_day_if, gmg_ctrl and gmg_dp.
//
//   channel  dir  fields                                          per transaction
//   req      in   year[11:0], month[3:0]                          one month request
//   day      out  day_number[4:0], week_row[2:0],                 one grid cell
//                 weekday_column[2:0], last
//
// A request passes through the weekday arithmetic (three register stages through the
// reciprocal multipliers, one load of the day walker), then emits one day per cycle while
// day is ready, and ends back in the request wait state.
// A month index above 11 is accepted and dropped with no result.
// Stalls on day hold the current cell; req is ready only while no month is in work.
// Reset clears the controller; datapath registers carry no reset.
module gregorian_month_grid_layout_top (
	input  logic clk,
	input  logic arst_n,
	gmg_req_if.sink   req,
	gmg_day_if.source day
);
	import gmg_pkg::*;

	cmd_t    cmd;
	status_t status;

	gmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.day_valid (day.valid),
		.day_ready (day.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gmg_dp u_dp (
		.clk            (clk),
		.year           (req.year),
		.month          (req.month),
		.cmd            (cmd),
		.status         (status),
		.day_number     (day.day_number),
		.week_row       (day.week_row),
		.weekday_column (day.weekday_column)
	);

	assign day.last = status.last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		day.valid |-> !req.ready)
		else $error("request taken while days are emitted");

	a_first_day: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.month <= LAST_MONTH)) |-> ##5
		(day.valid && (day.day_number == 5'd1) && (day.week_row == 3'd0)))
		else $error("first cell missing or misplaced");

	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(day.valid && day.ready && !day.last) |=>
		(day.valid && (day.day_number == $past(day.day_number) + 5'd1)))
		else $error("day sequence broken");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(day.valid && day.ready && day.last) |=> (!day.valid && req.ready))
		else $error("emission did not end after last day");

endmodule

[verif/gregorian_month_grid_layout_top_tb.sv]
// Regression bench for gregorian_month_grid_layout_top: month requests in, day cells out.
// Depends on gmg_pkg, both channel interfaces and the top level.
`timescale 1ns / 1ps

module gregorian_month_grid_layout_top_tb;
	import gmg_pkg::*;

	localparam int RANDOM_MONTHS = 100;
	localparam int TAIL_MONTHS   = 30;
	localparam int SETTLE_CYCLES = 50;
	localparam int EPOCH_YEAR    = 1583;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		logic [DayW-1:0] day_number;
		logic [RowW-1:0] week_row;
		logic [ColW-1:0] weekday_column;
		logic            last;
	} grid_cell_t;

	class month_grid_board;
		grid_cell_t cells[$];
		int         mismatches;

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int unsigned month_days(bit leap, int unsigned m);
			case (m)
				1:            return leap ? 29 : 28;
				3, 5, 8, 10:  return 30;
				default:      return 31;
			endcase
		endfunction

		function void note_request(logic [YearW-1:0] year, logic [MonthW-1:0] month);
			int unsigned weekday;
			int unsigned col;
			int unsigned row;
			int unsigned len;
			bit          leap;
			grid_cell_t  entry;
			if (month > LAST_MONTH) begin
				return;
			end
			weekday = 0;
			for (int unsigned y = EPOCH_YEAR; y < year; y++) begin
				weekday = (weekday + (is_leap(y) ? 366 : 365)) % 7;
			end
			leap = is_leap(year);
			for (int unsigned m = 0; m < month; m++) begin
				weekday = (weekday + month_days(leap, m)) % 7;
			end
			col = (weekday + 6) % 7;
			row = 0;
			len = month_days(leap, month);
			for (int unsigned d = 1; d <= len; d++) begin
				entry.day_number     = d[DayW-1:0];
				entry.week_row       = row[RowW-1:0];
				entry.weekday_column = col[ColW-1:0];
				entry.last           = (d == len);
				cells.push_back(entry);
				col++;
				if (col == 7) begin
					col = 0;
					row++;
				end
			end
		endfunction

		function void check_cell(grid_cell_t got);
			grid_cell_t want;
			if (cells.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected cell day %0d row %0d col %0d last %0d", got.day_number,
						got.week_row, got.weekday_column, got.last);
				end
				return;
			end
			want = cells.pop_front();
			if (got.day_number !== want.day_number || got.week_row !== want.week_row ||
					got.weekday_column !== want.weekday_column || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("expected day/row/col/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
						want.day_number, want.week_row, want.weekday_column, want.last,
						got.day_number, got.week_row, got.weekday_column, got.last);
				end
			end
		endfunction

		function int pending();
			return cells.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet_tail;

	gmg_req_if req_ch ();
	gmg_day_if day_ch ();

	month_grid_board board = new();

	gregorian_month_grid_layout_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.day    (day_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_request(logic [YearW-1:0] year, logic [MonthW-1:0] month);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.year  = year;
		req_ch.month = month;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		board.note_request(year, month);
	endtask

	task automatic hold_requests(int cycles);
		@(negedge clk);
		req_ch.valid = 1'b0;
		req_ch.year  = YearW'($urandom);
		req_ch.month = MonthW'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_cells();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!quiet_tail && $urandom_range(0, 2) == 0) begin
			hold_requests($urandom_range(1, 11));
		end
	endtask

	initial begin
		int hold;
		day_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (quiet_tail) begin
				day_ch.ready = 1'b1;
			end else if (hold > 0) begin
				day_ch.ready = 1'b0;
				hold--;
			end else if ($urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 11) - 1;
				day_ch.ready = 1'b0;
			end else begin
				day_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		grid_cell_t got;
		if (arst_n && day_ch.valid && day_ch.ready) begin
			got.day_number     = day_ch.day_number;
			got.week_row       = day_ch.week_row;
			got.weekday_column = day_ch.weekday_column;
			got.last           = day_ch.last;
			board.check_cell(got);
		end
	end

	initial begin
		int          dir_year [13] = '{1583, 4040, 2000, 2024, 1600, 0, 1582, 4095, 4041,
			2730, 3333, 4095, 0};
		int          dir_month [13] = '{0, 11, 1, 1, 1, 1, 5, 2, 6, 12, 15, 13, 14};
		int          counted;
		bit          drained;
		int unsigned y;
		int unsigned m;
		arst_n       = 1'b0;
		quiet_tail   = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.year  = '0;
		req_ch.month = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 13; i++) begin
			maybe_gap();
			send_request(YearW'(dir_year[i]), MonthW'(dir_month[i]));
		end
		for (int i = 0; i <= LAST_MONTH; i++) begin
			maybe_gap();
			send_request(YearW'(2100), MonthW'(i));
		end

		counted = 0;
		drained = 1'b0;
		while (counted < RANDOM_MONTHS) begin
			quiet_tail = (counted >= RANDOM_MONTHS - TAIL_MONTHS);
			if (!drained && counted >= RANDOM_MONTHS / 2) begin
				drain_cells();
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0:       y = $urandom_range(0, EPOCH_YEAR - 1);
				1:       y = $urandom_range(4041, 4095);
				2:       y = $urandom_range(16, 40) * 100;
				default: y = $urandom_range(EPOCH_YEAR, 4040);
			endcase
			if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				m = $urandom_range(LAST_MONTH + 1, 15);
			end else begin
				m = $urandom_range(0, LAST_MONTH);
			end
			maybe_gap();
			send_request(YearW'(y), MonthW'(m));
			if (m <= LAST_MONTH) begin
				counted++;
			end
		end

		drain_cells();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("gregorian_month_grid_layout_top regression: pass");
		end else begin
			$display("gregorian_month_grid_layout_top regression: fail");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("gregorian_month_grid_layout_top regression: fail");
		$finish;
	end

endmodule
